// File: sv/blaq_pkg.sv
// shared constants and types for the byte line assembler queue
package blaq_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned OUT_LEN_W = 6;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_SMALL = 2'd2
	} status_t;

endpackage

// File: sv/byte_line_assembler_queue.sv
// byte line assembler with a ring queue of completed lines held in one line memory
// push beat: gives no output beat
// pop beat: moves to the stream state, then one character beat per cycle unless stalled
// a pop holds the input until every character is read (one memory read per character)
// failed pop: one status beat in the cycle after acceptance
// reset clears pointers, counts and flags; line memory and lengths are not cleared
module byte_line_assembler_queue #(
	parameter int MAX_LINES    = 8,
	parameter int MAX_LINE_LEN = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [blaq_pkg::DATA_W-1:0]   s_tdata,  // data_byte, out_capacity
	input  logic                          s_tuser,  // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [blaq_pkg::DATA_W-1:0]   m_tdata,  // char_out, line_len, zero fill
	output logic [1:0]                    m_tuser,  // status
	output logic                          m_tlast
);

	localparam int NSLOTS = MAX_LINES + 1;
	localparam int SLOT_W = $clog2(NSLOTS);
	localparam int CNT_W  = $clog2(MAX_LINES + 1);
	localparam int LEN_W  = $clog2(MAX_LINE_LEN + 1);
	localparam int DEPTH  = NSLOTS * MAX_LINE_LEN;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  rd_q;
	logic [SLOT_W-1:0]  wr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEN_W-1:0]   asm_len_q;
	logic               drop_q;
	logic [LEN_W-1:0]   k_q;
	logic [LEN_W-1:0]   plen_q;
	logic               out_valid_q;
	blaq_pkg::status_t  status_q;
	logic [LEN_W-1:0]   olen_q;
	logic               last_q;
	logic [7:0]         char_q;

	logic [7:0]         mem [DEPTH];
	logic [LEN_W-1:0]   lens_q [NSLOTS];

	logic               in_acc;
	logic               is_push;
	logic               is_pop;
	logic [7:0]         in_byte;
	logic [7:0]         in_cap;
	logic               is_term;
	logic               out_free;
	logic               commit;
	logic               mem_we;
	logic [ADDR_W-1:0]  waddr;
	logic [ADDR_W-1:0]  raddr;
	logic [LEN_W-1:0]   head_len;
	logic               pop_fail;
	blaq_pkg::status_t  fail_code;
	logic               rd_en;
	logic               out_load;
	logic               k_last;
	logic [SLOT_W-1:0]  rd_next;
	logic [SLOT_W-1:0]  wr_next;

	assign in_byte  = s_tdata[7:0];
	assign in_cap   = s_tdata[15:8];
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;
	assign is_push  = in_acc && (s_tuser == blaq_pkg::MODE_PUSH);
	assign is_pop   = in_acc && (s_tuser == blaq_pkg::MODE_POP);
	assign is_term  = (in_byte == blaq_pkg::CH_LF) || (in_byte == blaq_pkg::CH_CR);

	assign commit = is_push && is_term && !drop_q && (asm_len_q != '0);
	assign mem_we = is_push && !is_term && !drop_q
		&& (asm_len_q < LEN_W'(MAX_LINE_LEN));

	assign rd_next = (rd_q == SLOT_W'(NSLOTS - 1)) ? '0 : rd_q + 1'b1;
	assign wr_next = (wr_q == SLOT_W'(NSLOTS - 1)) ? '0 : wr_q + 1'b1;

	// the line being assembled sits in the slot just past the queued lines
	assign waddr = ADDR_W'(wr_q) * ADDR_W'(MAX_LINE_LEN) + ADDR_W'(asm_len_q);
	assign raddr = ADDR_W'(rd_q) * ADDR_W'(MAX_LINE_LEN) + ADDR_W'(k_q);

	assign head_len = lens_q[rd_q];

	always_comb begin
		pop_fail  = 1'b1;
		fail_code = blaq_pkg::STAT_SMALL;
		if (in_cap == 8'd0) begin
			fail_code = blaq_pkg::STAT_SMALL;
		end else if (cnt_q == '0) begin
			fail_code = blaq_pkg::STAT_EMPTY;
		end else if (head_len == '0 || (9'(head_len) + 9'd1) > 9'(in_cap)) begin
			fail_code = blaq_pkg::STAT_SMALL;
		end else begin
			pop_fail = 1'b0;
		end
	end

	assign rd_en    = (state_q == ST_STREAM) && out_free;
	assign out_load = (is_pop && pop_fail) || rd_en;
	assign k_last   = (k_q == plen_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_q        <= '0;
			wr_q        <= '0;
			cnt_q       <= '0;
			asm_len_q   <= '0;
			drop_q      <= 1'b0;
			k_q         <= '0;
			plen_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= blaq_pkg::STAT_OK;
			olen_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_push) begin
						if (is_term) begin
							asm_len_q <= '0;
							drop_q    <= 1'b0;
							if (commit) begin
								wr_q <= wr_next;
								if (cnt_q == CNT_W'(MAX_LINES)) begin
									rd_q <= rd_next;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
						end else if (!drop_q) begin
							if (mem_we) begin
								asm_len_q <= asm_len_q + 1'b1;
							end else begin
								drop_q <= 1'b1;
							end
						end
					end else if (is_pop) begin
						if (pop_fail) begin
							status_q    <= fail_code;
							olen_q      <= '0;
							last_q      <= 1'b1;
						end else begin
							k_q     <= '0;
							plen_q  <= head_len;
							state_q <= ST_STREAM;
						end
					end
				end
				ST_STREAM: begin
					if (rd_en) begin
						status_q    <= blaq_pkg::STAT_OK;
						olen_q      <= plen_q;
						last_q      <= k_last;
						k_q         <= k_q + 1'b1;
						if (k_last) begin
							rd_q    <= rd_next;
							cnt_q   <= cnt_q - 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= in_byte;
		end
		if (rd_en) begin
			char_q <= mem[raddr];
		end else if (is_pop && pop_fail) begin
			char_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			lens_q[wr_q] <= asm_len_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, blaq_pkg::OUT_LEN_W'(olen_q), char_q};
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

	logic [SLOT_W:0] tail_sum;
	logic [SLOT_W-1:0] tail_slot;

	assign tail_sum  = (SLOT_W + 1)'(rd_q) + (SLOT_W + 1)'(cnt_q);
	assign tail_slot = (tail_sum >= (SLOT_W + 1)'(NSLOTS))
		? SLOT_W'(tail_sum - (SLOT_W + 1)'(NSLOTS)) : SLOT_W'(tail_sum);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_LINES))
		else $error("line count above queue depth");

	a_ring_tail: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q == tail_slot)
		else $error("assembly slot overlaps queued lines");

	a_stream_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STREAM) |-> (k_q < plen_q) && (cnt_q != '0))
		else $error("character index out of range of popped line");

	a_fail_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != blaq_pkg::STAT_OK) |-> m_tlast && m_tdata == '0)
		else $error("failure beat carries data");

endmodule
